// File: sv/slot_mailbox_with_reply_macros.svh
// ----------------------------------------------------------------------------
// Slot mailbox assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SLOT_MAILBOX_WITH_REPLY_MACROS_SVH
`define SLOT_MAILBOX_WITH_REPLY_MACROS_SVH

// Plain property check
`define SMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication
`define SMB_ASSERT_IMP(lbl, ante, cons, msg) \
  `SMB_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define SMB_ASSERT_NXT(lbl, ante, cons, msg) \
  `SMB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/smb_pkg.sv
// ----------------------------------------------------------------------------
// smb_pkg
// Shared types and codes of the slot mailbox.
// ----------------------------------------------------------------------------
`default_nettype none

package smb_pkg;

  localparam int SLOTS_DEF     = 8;
  localparam int DATA_BITS_DEF = 32;
  localparam int CODE_BITS_DEF = 16;

  // commands
  localparam logic [2:0] CMD_POST    = 3'd0;
  localparam logic [2:0] CMD_FETCH   = 3'd1;
  localparam logic [2:0] CMD_REPLY   = 3'd2;
  localparam logic [2:0] CMD_COLLECT = 3'd3;
  localparam logic [2:0] CMD_REMOVE  = 3'd4;

  // slot states
  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_POSTED      = 3'd1;
  localparam logic [2:0] ST_AWAIT       = 3'd2;
  localparam logic [2:0] ST_REPLIED     = 3'd3;
  localparam logic [2:0] ST_REPLIED_ERR = 3'd4;

  // status codes
  localparam logic [2:0] RC_SUCCESS     = 3'd0;
  localparam logic [2:0] RC_NO_SPACE    = 3'd1;
  localparam logic [2:0] RC_NO_MESSAGES = 3'd2;
  localparam logic [2:0] RC_NO_REPLY    = 3'd3;
  localparam logic [2:0] RC_INVALID     = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  slot_index;
    logic [15:0] msg_code;
    logic [31:0] msg_data;
    logic        wants_reply;
    logic        is_error;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [2:0]  slot_state_out;
    logic [15:0] code_out;
    logic [31:0] data_out;
  } rsp_t;

  // verdict of the slot check unit for one examined slot
  typedef struct packed {
    logic       done;
    logic       show_slot;
    logic       copy;
    logic       st_we;
    logic [2:0] st_new;
    logic       code_we;
    logic       data_we;
    logic [2:0] status;
  } chk_t;

  // write strobes toward the slot stores
  typedef struct packed {
    logic st;
    logic code;
    logic data;
  } wr_t;

endpackage

`default_nettype wire

// File: sv/smb_ram.sv
// ----------------------------------------------------------------------------
// smb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smb_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/smb_slot_check.sv
// ----------------------------------------------------------------------------
// smb_slot_check
// Compare unit: judges one slot state against the current command.
// ----------------------------------------------------------------------------
`default_nettype none

module smb_slot_check (
  input  wire logic [2:0]   cmd_i,
  input  wire logic [2:0]   st_i,
  input  wire logic         wants_i,
  input  wire logic         err_i,
  input  wire logic         idx_ok_i,
  input  wire logic         last_i,
  output smb_pkg::chk_t     chk_o
);

  always_comb begin
    chk_o           = '0;
    chk_o.done      = 1'b1;
    chk_o.st_new    = smb_pkg::ST_IDLE;
    chk_o.status    = smb_pkg::RC_INVALID;
    case (cmd_i)
      smb_pkg::CMD_POST: begin
        if (st_i == smb_pkg::ST_IDLE) begin
          chk_o.st_we     = 1'b1;
          chk_o.st_new    = wants_i ? smb_pkg::ST_AWAIT : smb_pkg::ST_POSTED;
          chk_o.code_we   = 1'b1;
          chk_o.data_we   = 1'b1;
          chk_o.show_slot = 1'b1;
          chk_o.status    = smb_pkg::RC_SUCCESS;
        end else if (last_i) begin
          chk_o.status = smb_pkg::RC_NO_SPACE;
        end else begin
          chk_o.done = 1'b0;
        end
      end
      smb_pkg::CMD_FETCH: begin
        if (st_i inside {smb_pkg::ST_POSTED, smb_pkg::ST_AWAIT}) begin
          chk_o.copy      = 1'b1;
          chk_o.show_slot = 1'b1;
          chk_o.st_we     = (st_i == smb_pkg::ST_POSTED);
          chk_o.status    = smb_pkg::RC_SUCCESS;
        end else if (last_i) begin
          chk_o.status = smb_pkg::RC_NO_MESSAGES;
        end else begin
          chk_o.done = 1'b0;
        end
      end
      smb_pkg::CMD_REPLY: begin
        if (idx_ok_i && st_i == smb_pkg::ST_AWAIT) begin
          chk_o.st_we   = 1'b1;
          chk_o.st_new  = err_i ? smb_pkg::ST_REPLIED_ERR : smb_pkg::ST_REPLIED;
          chk_o.data_we = 1'b1;
          chk_o.status  = smb_pkg::RC_SUCCESS;
        end
      end
      smb_pkg::CMD_COLLECT: begin
        if (idx_ok_i) begin
          if (st_i == smb_pkg::ST_AWAIT) begin
            chk_o.status = smb_pkg::RC_NO_REPLY;
          end else if (st_i inside {smb_pkg::ST_REPLIED, smb_pkg::ST_REPLIED_ERR}) begin
            chk_o.copy   = 1'b1;
            chk_o.st_we  = 1'b1;
            chk_o.status = smb_pkg::RC_SUCCESS;
          end
        end
      end
      smb_pkg::CMD_REMOVE: begin
        if (idx_ok_i && (st_i inside {smb_pkg::ST_POSTED, smb_pkg::ST_AWAIT})) begin
          chk_o.st_we  = 1'b1;
          chk_o.status = smb_pkg::RC_SUCCESS;
        end
      end
      default: begin
        chk_o.status = smb_pkg::RC_INVALID;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/smb_ctrl.sv
// ----------------------------------------------------------------------------
// smb_ctrl
// Sequencer: walks the slot pointer, drives the check unit, writes back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slot_mailbox_with_reply_macros.svh"

module smb_ctrl #(
  parameter  int SLOTS     = smb_pkg::SLOTS_DEF,
  parameter  int DATA_BITS = smb_pkg::DATA_BITS_DEF,
  parameter  int CODE_BITS = smb_pkg::CODE_BITS_DEF,
  localparam int PTR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire smb_pkg::req_t        req_i,
  output logic                      done_o,
  output smb_pkg::rsp_t             rsp_o,
  output logic     [PTR_W-1:0]      raddr_o,
  output logic     [PTR_W-1:0]      waddr_o,
  output smb_pkg::wr_t              wr_o,
  output logic     [2:0]            st_wdata_o,
  output logic     [CODE_BITS-1:0]  code_wdata_o,
  output logic     [DATA_BITS-1:0]  data_wdata_o,
  input  wire logic [2:0]           st_rd_i,
  input  wire logic [CODE_BITS-1:0] code_rd_i,
  input  wire logic [DATA_BITS-1:0] data_rd_i
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_CHECK = 1'b1;

  logic                 state_q, state_d;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [2:0]           cmd_q;
  logic                 wants_q, err_q, idx_ok_q;
  logic [CODE_BITS-1:0] code_q;
  logic [DATA_BITS-1:0] data_q;
  logic [SLOTS-1:0]     valid_q;
  logic                 done_q, done_d;
  smb_pkg::rsp_t        rsp_q, rsp_d;
  smb_pkg::chk_t        chk;
  logic [2:0]           eff_st;
  logic                 last;
  logic                 accept;
  logic                 by_index;

  assign accept   = start_i && (state_q == S_IDLE);
  assign by_index = (req_i.command == smb_pkg::CMD_REPLY) ||
                    (req_i.command == smb_pkg::CMD_COLLECT) ||
                    (req_i.command == smb_pkg::CMD_REMOVE);

  // a slot never written since reset reads as idle
  assign eff_st = valid_q[ptr_q] ? st_rd_i : smb_pkg::ST_IDLE;
  assign last   = (ptr_q == PTR_W'(SLOTS - 1));

  smb_slot_check u_check (
    .cmd_i    (cmd_q),
    .st_i     (eff_st),
    .wants_i  (wants_q),
    .err_i    (err_q),
    .idx_ok_i (idx_ok_q),
    .last_i   (last),
    .chk_o    (chk)
  );

  // read address runs one step ahead so the RAM output matches ptr_q
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    wr_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
          ptr_d   = by_index ? PTR_W'(req_i.slot_index) : '0;
        end
      end
      S_CHECK: begin
        if (chk.done) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          wr_o.st   = chk.st_we;
          wr_o.code = chk.code_we;
          wr_o.data = chk.data_we;
          rsp_d.status         = chk.status;
          rsp_d.slot_out       = chk.show_slot ? 3'(ptr_q) : 3'd0;
          rsp_d.slot_state_out = chk.copy ? eff_st : smb_pkg::ST_IDLE;
          rsp_d.code_out       = chk.copy ? 16'(code_rd_i) : 16'd0;
          rsp_d.data_out       = chk.copy ? 32'(data_rd_i) : 32'd0;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign raddr_o      = ptr_d;
  assign waddr_o      = ptr_q;
  assign st_wdata_o   = chk.st_new;
  assign code_wdata_o = code_q;
  assign data_wdata_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ptr_q   <= ptr_d;
      if (wr_o.st) begin
        valid_q[ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      cmd_q    <= req_i.command;
      wants_q  <= req_i.wants_reply;
      err_q    <= req_i.is_error;
      idx_ok_q <= int'(req_i.slot_index) < SLOTS;
      code_q   <= CODE_BITS'(req_i.msg_code);
      data_q   <= DATA_BITS'(req_i.msg_data);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `SMB_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "result while still checking")
  `SMB_ASSERT_NXT(a_start_busy, start_i && !busy_o, state_q == S_CHECK, "accepted item not taken")
  `SMB_ASSERT_IMP(a_index_one_step, state_q == S_CHECK && cmd_q != smb_pkg::CMD_POST && cmd_q != smb_pkg::CMD_FETCH, chk.done, "indexed command must finish in one check")
  `SMB_ASSERT_IMP(a_scan_range, state_q == S_CHECK && (cmd_q == smb_pkg::CMD_POST || cmd_q == smb_pkg::CMD_FETCH), int'(ptr_q) < SLOTS, "scan pointer past last slot")
  `SMB_ASSERT_IMP(a_no_copy_on_fail, done_q && rsp_q.status != smb_pkg::RC_SUCCESS, rsp_q.slot_state_out == smb_pkg::ST_IDLE && rsp_q.slot_out == 3'd0, "failed item carries slot contents")

endmodule

`default_nettype wire

// File: sv/slot_mailbox_with_reply.sv
// ----------------------------------------------------------------------------
// slot_mailbox_with_reply
// One direction of a two-core mailbox with a table of reply-capable slots.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------
//  command  | start / busy            | req_i  (smb_pkg::req_t)
//  result   | done_o, one-cycle pulse | rsp_o  (smb_pkg::rsp_t)
//
//  Reply, collect and remove examine only the slot named by slot_index.
//  Post and fetch scan one slot per cycle through the slot RAMs from slot 0,
//  stopping at the first matching slot or after the last slot.
//  busy is high from the accept until the result cycle; one item at a time.
//  The result stands for one cycle only; the receiver cannot stall it.
//  Reset clears every slot to idle at once through per-slot valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_mailbox_with_reply #(
  parameter int SLOTS     = smb_pkg::SLOTS_DEF,
  parameter int DATA_BITS = smb_pkg::DATA_BITS_DEF,
  parameter int CODE_BITS = smb_pkg::CODE_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire smb_pkg::req_t req_i,
  output logic               done_o,
  output smb_pkg::rsp_t      rsp_o
);

  localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [PTR_W-1:0]     raddr, waddr;
  smb_pkg::wr_t         wr;
  logic [2:0]           st_wdata, st_rd;
  logic [CODE_BITS-1:0] code_wdata, code_rd;
  logic [DATA_BITS-1:0] data_wdata, data_rd;

  smb_ctrl #(
    .SLOTS     (SLOTS),
    .DATA_BITS (DATA_BITS),
    .CODE_BITS (CODE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .req_i        (req_i),
    .done_o       (done_o),
    .rsp_o        (rsp_o),
    .raddr_o      (raddr),
    .waddr_o      (waddr),
    .wr_o         (wr),
    .st_wdata_o   (st_wdata),
    .code_wdata_o (code_wdata),
    .data_wdata_o (data_wdata),
    .st_rd_i      (st_rd),
    .code_rd_i    (code_rd),
    .data_rd_i    (data_rd)
  );

  smb_ram #(.WIDTH(3), .DEPTH(SLOTS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr.st),
    .waddr_i (waddr),
    .wdata_i (st_wdata),
    .raddr_i (raddr),
    .rdata_o (st_rd)
  );

  smb_ram #(.WIDTH(CODE_BITS), .DEPTH(SLOTS)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (wr.code),
    .waddr_i (waddr),
    .wdata_i (code_wdata),
    .raddr_i (raddr),
    .rdata_o (code_rd)
  );

  smb_ram #(.WIDTH(DATA_BITS), .DEPTH(SLOTS)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (wr.data),
    .waddr_i (waddr),
    .wdata_i (data_wdata),
    .raddr_i (raddr),
    .rdata_o (data_rd)
  );

endmodule

`default_nettype wire
